[hw/rtl/ogi_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ogi_pkg
// Shared types and constants of the occupancy grid inflation unit.
// ----------------------------------------------------------------------------
package ogi_pkg;

   localparam logic [7:0] CELL_OBSTACLE = 8'd0;
   localparam logic [7:0] CELL_FREE     = 8'd255;
   localparam logic [7:0] CELL_INFLATED = 8'd5;

   localparam logic [1:0] ACT_WRITE   = 2'd0;
   localparam logic [1:0] ACT_INFLATE = 2'd1;
   localparam logic [1:0] ACT_CHECK   = 2'd2;

   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_RADIUS = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_WAIT,
      ST_SCAN_TEST,
      ST_NB_RD,
      ST_NB_WAIT,
      ST_NB_TEST,
      ST_CHK_RD,
      ST_CHK_WAIT,
      ST_CHK_TEST,
      ST_RESP
   } state_type;

endpackage
`default_nettype wire

[hw/rtl/occupancy_grid_inflation_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// occupancy_grid_inflation_unit
// Occupancy grid store with obstacle inflation and footprint check.
// ----------------------------------------------------------------------------
// One item at a time against a single-port grid RAM with registered read.
// A write takes the accept step and the result step. An inflate takes the
// accept step, reads each rectangle cell and, for every obstacle found, each
// cell of the clamped (2r+1)^2 window, then closes the walk and gives the
// result. A check takes the accept step, reads each in-map cell of the
// (2*(r/2)+1)^2 window and passes each cell outside the map without a read,
// stops at the first hit, and otherwise closes the walk, then gives the
// result. The single RAM port serves one read or write at a time. One result
// item per input item; cells must be written before they are read.
module occupancy_grid_inflation_unit #(
   parameter int GRID_COLS  = 256,
   parameter int GRID_ROWS  = 256,
   parameter int MAX_RADIUS = 15
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // col[7:0], row[15:8], span_cols[24:16], span_rows[33:25], cell_value[41:34]
   input  wire logic [47:0] req_tdata,
   input  wire logic [1:0]  req_tuser,   // action[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [7:0]  rsp_tdata,   // footprint_clear[0], status[1]
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [8:0]  csr_wdata
);
   import ogi_pkg::*;

   localparam int CW = $clog2(GRID_COLS);
   localparam int RW = $clog2(GRID_ROWS);
   localparam int AW = CW + RW;
   localparam int SW = 14;   // signed coordinate width

   state_type state_ff, state_in;

   logic [8:0] width_ff, height_ff;
   logic [3:0] radius_ff;
   logic [1:0] act_ff;
   logic [SW-1:0] c_ff, r_ff, x_ff, y_ff, xe_ff, ye_ff, y0_ff;
   logic [SW-1:0] nx_ff, ny_ff, ny0_ff, nx1_ff, ny1_ff;
   logic [SW-1:0] bx_ff, by_ff, bx_in, by_in;
   logic [7:0] val_ff;
   logic       clear_ff, status_ff;
   logic [SW-1:0] map_w, map_h, rad, half;
   logic [SW-1:0] x_in, y_in, nx_in, ny_in;
   logic [SW-1:0] nx0_in, ny0_in, nx1_in, ny1_in;
   logic       clear_in, status_in;
   logic       ram_we;
   logic [AW-1:0] ram_addr;
   logic [7:0] ram_wdata, ram_rdata;
   logic [SW-1:0] ddx, ddy, d2, lim, rsq;
   logic       accept, in_map;

   assign accept = req_tvalid && req_tready;
   assign map_w = (SW'(width_ff) < SW'(GRID_COLS)) ? SW'(width_ff) : SW'(GRID_COLS);
   assign map_h = (SW'(height_ff) < SW'(GRID_ROWS)) ? SW'(height_ff) : SW'(GRID_ROWS);
   assign rad   = (SW'(radius_ff) < SW'(MAX_RADIUS)) ? SW'(radius_ff) : SW'(MAX_RADIUS);
   assign half  = rad >>> 1;
   assign rsq   = SW'(rad * rad);
   assign lim   = rsq >>> 2;

   ogi_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_ram (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr),
      .wr_data(ram_wdata), .rd_data(ram_rdata)
   );

   // address and distance of the cell in hand
   always_comb begin
      bx_in = x_ff;
      by_in = y_ff;
      unique case (state_ff)
         ST_IDLE: begin
            bx_in = x_in;
            by_in = y_in;
         end
         ST_NB_RD, ST_NB_WAIT, ST_NB_TEST: begin
            bx_in = nx_ff;
            by_in = ny_ff;
         end
         default: begin
         end
      endcase
      ddx = (state_ff == ST_NB_TEST) ? nx_ff - x_ff : x_ff - c_ff;
      ddy = (state_ff == ST_NB_TEST) ? ny_ff - y_ff : y_ff - r_ff;
      d2  = SW'(ddx * ddx) + SW'(ddy * ddy);
      in_map = !x_ff[SW-1] && !y_ff[SW-1] &&
               $signed(x_ff) < $signed(map_w) && $signed(y_ff) < $signed(map_h);
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_wdata = val_ff;
      ram_addr  = {by_ff[RW-1:0], bx_ff[CW-1:0]};
      if (state_ff == ST_NB_TEST && ram_rdata == CELL_FREE &&
          $signed(d2) <= $signed(rsq)) begin
         ram_we    = 1'b1;
         ram_wdata = CELL_INFLATED;
      end else if (state_ff == ST_RESP && act_ff == ACT_WRITE && !status_ff &&
                   rsp_tready) begin
         ram_we = 1'b1;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == ACT_INFLATE) state_in = ST_SCAN_RD;
               else if (req_tuser == ACT_CHECK) state_in = ST_CHK_RD;
               else state_in = ST_RESP;
            end
         end
         ST_SCAN_RD: begin
            if ($signed(x_ff) >= $signed(xe_ff) || $signed(y_ff) >= $signed(ye_ff))
               state_in = ST_RESP;
            else state_in = ST_SCAN_WAIT;
         end
         ST_SCAN_WAIT: state_in = ST_SCAN_TEST;
         ST_SCAN_TEST: state_in = (ram_rdata == CELL_OBSTACLE) ? ST_NB_RD : ST_SCAN_RD;
         ST_NB_RD:     state_in = ST_NB_WAIT;
         ST_NB_WAIT:   state_in = ST_NB_TEST;
         ST_NB_TEST: begin
            if (ny_ff == ny1_ff && nx_ff == nx1_ff) state_in = ST_SCAN_RD;
            else state_in = ST_NB_RD;
         end
         ST_CHK_RD: begin
            if ($signed(x_ff) > $signed(c_ff + half)) state_in = ST_RESP;
            else if (in_map) state_in = ST_CHK_WAIT;
         end
         ST_CHK_WAIT:  state_in = ST_CHK_TEST;
         ST_CHK_TEST: begin
            if ($signed(d2) < $signed(lim) &&
                (ram_rdata == CELL_INFLATED || ram_rdata == CELL_OBSTACLE))
               state_in = ST_RESP;
            else state_in = ST_CHK_RD;
         end
         ST_RESP:      if (rsp_tready) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // datapath updates
   always_comb begin
      x_in = x_ff; y_in = y_ff; nx_in = nx_ff; ny_in = ny_ff;
      nx0_in = '0; ny0_in = ny0_ff; nx1_in = nx1_ff; ny1_in = ny1_ff;
      clear_in = clear_ff; status_in = status_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               clear_in  = 1'b0;
               status_in = (req_tuser == ACT_WRITE) &&
                           !(SW'(req_tdata[7:0]) < map_w && SW'(req_tdata[15:8]) < map_h);
               if (req_tuser == ACT_CHECK) begin
                  x_in = SW'(req_tdata[7:0]) - half;
                  y_in = SW'(req_tdata[15:8]) - half;
               end else begin
                  x_in = SW'(req_tdata[7:0]);
                  y_in = SW'(req_tdata[15:8]);
               end
            end
         end
         ST_SCAN_TEST: begin
            // advance rectangle walk, rows inner
            if ($signed(y_ff + SW'(1)) < $signed(ye_ff)) y_in = y_ff + SW'(1);
            else begin
               y_in = y0_ff;
               x_in = x_ff + SW'(1);
            end
            nx0_in = ($signed(x_ff - rad) < 0) ? '0 : x_ff - rad;
            ny0_in = ($signed(y_ff - rad) < 0) ? '0 : y_ff - rad;
            nx1_in = ($signed(x_ff + rad) < $signed(map_w)) ? x_ff + rad : map_w - SW'(1);
            ny1_in = ($signed(y_ff + rad) < $signed(map_h)) ? y_ff + rad : map_h - SW'(1);
            nx_in  = nx0_in;
            ny_in  = ny0_in;
            // keep obstacle position for the window
            if (ram_rdata == CELL_OBSTACLE) begin
               x_in = x_ff;
               y_in = y_ff;
            end
         end
         ST_NB_TEST: begin
            if (ny_ff != ny1_ff) ny_in = ny_ff + SW'(1);
            else begin
               ny_in = ny0_ff;
               nx_in = nx_ff + SW'(1);
            end
            if (ny_ff == ny1_ff && nx_ff == nx1_ff) begin
               if ($signed(y_ff + SW'(1)) < $signed(ye_ff)) y_in = y_ff + SW'(1);
               else begin
                  y_in = y0_ff;
                  x_in = x_ff + SW'(1);
               end
            end
         end
         ST_CHK_RD: begin
            if ($signed(x_ff) > $signed(c_ff + half)) clear_in = 1'b1;
            else if (!in_map) begin
               if ($signed(y_ff) < $signed(r_ff + half)) y_in = y_ff + SW'(1);
               else begin
                  y_in = r_ff - half;
                  x_in = x_ff + SW'(1);
               end
            end
         end
         ST_CHK_TEST: begin
            if ($signed(y_ff) < $signed(r_ff + half)) y_in = y_ff + SW'(1);
            else begin
               y_in = r_ff - half;
               x_in = x_ff + SW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         width_ff  <= 9'd256;
         height_ff <= 9'd256;
         radius_ff <= 4'd4;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_WIDTH:  width_ff  <= csr_wdata;
               REG_HEIGHT: height_ff <= csr_wdata;
               REG_RADIUS: radius_ff <= csr_wdata[3:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      bx_ff <= bx_in; by_ff <= by_in;
      x_ff <= x_in; y_ff <= y_in; nx_ff <= nx_in; ny_ff <= ny_in;
      ny0_ff <= ny0_in; nx1_ff <= nx1_in; ny1_ff <= ny1_in;
      clear_ff <= clear_in; status_ff <= status_in;
      if (accept) begin
         act_ff    <= req_tuser;
         c_ff      <= SW'(req_tdata[7:0]);
         r_ff      <= SW'(req_tdata[15:8]);
         val_ff    <= req_tdata[41:34];
         y0_ff <= SW'(req_tdata[15:8]);
         xe_ff <= ((SW'(req_tdata[7:0]) + SW'(req_tdata[24:16])) < map_w) ?
                  SW'(req_tdata[7:0]) + SW'(req_tdata[24:16]) : map_w;
         ye_ff <= ((SW'(req_tdata[15:8]) + SW'(req_tdata[33:25])) < map_h) ?
                  SW'(req_tdata[15:8]) + SW'(req_tdata[33:25]) : map_h;
      end
   end

   // outputs
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      rsp_tvalid = (state_ff == ST_RESP);
      rsp_tdata  = {6'd0, status_ff, clear_ff && (act_ff == ACT_CHECK)};
   end

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input and result both open");
   a_we_state: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_NB_TEST || state_ff == ST_RESP))
      else $error("grid write outside a write state");
   a_resp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("result dropped");
endmodule
`default_nettype wire

[hw/rtl/ogi_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ogi_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module ogi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire
